>>> src/lts_pkg.sv
// Shared types and constants for the layered topological sort block.
// No dependencies; used by lts_ctrl, lts_datapath and layered_topological_sort.
package lts_pkg;

   localparam int NODE_INDEX_WIDTH = 5;
   localparam int NODE_COUNT_WIDTH = 6;

   // request kinds
   localparam logic REQ_ADD_EDGE = 1'b0;
   localparam logic REQ_RUN      = 1'b1;

   typedef struct packed {
      logic                        req_type;
      logic [NODE_INDEX_WIDTH-1:0] edge_source;
      logic [NODE_INDEX_WIDTH-1:0] edge_target;
   } req_item_type;

   typedef struct packed {
      logic [NODE_INDEX_WIDTH-1:0] node_index;
      logic                        node_valid;
      logic                        last_of_order;
      logic                        order_incomplete;
   } rsp_item_type;

   // controller -> datapath
   typedef struct packed {
      logic add_edge;
      logic start_run;
      logic count_row;
      logic load_layer;
      logic emit_step;
      logic finish;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic row_done;
      logic layer_empty;
      logic mask_empty;
      logic pending_valid;
      logic out_free;
   } status_type;

endpackage

>>> src/lts_ctrl.sv
// Sequencer for the layered topological sort: idle/edge load, in-degree count,
// layer pick, per-node emit and final result. Depends on lts_pkg.
module lts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_kind,
   output logic                req_ready,
   input  lts_pkg::status_type status,
   output lts_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_COUNT  = 3'd1;
   localparam logic [2:0] ST_LAYER  = 3'd2;
   localparam logic [2:0] ST_EMIT   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == lts_pkg::REQ_RUN) begin
                  cmd.start_run = 1'b1;
                  state_in      = ST_COUNT;
               end else begin
                  cmd.add_edge = 1'b1;
               end
            end
         end
         ST_COUNT: begin
            if (status.row_done) begin
               state_in = ST_LAYER;
            end else begin
               cmd.count_row = 1'b1;
            end
         end
         ST_LAYER: begin
            if (status.layer_empty) begin
               state_in = ST_FINISH;
            end else begin
               cmd.load_layer = 1'b1;
               state_in       = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.mask_empty) begin
               state_in = ST_LAYER;
            end else if (!status.pending_valid || status.out_free) begin
               cmd.emit_step = 1'b1;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> src/lts_datapath.sv
// Datapath: adjacency bit store, in-degree lanes, visited/layer masks,
// lowest-index picker, held result and output register. Depends on lts_pkg.
module lts_datapath #(
   parameter int NODE_LIMIT = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lts_pkg::cmd_type                      cmd,
   output lts_pkg::status_type                   status,
   input  lts_pkg::req_item_type                 req_item,
   input  logic                                  csr_write_enable,
   input  logic [lts_pkg::NODE_COUNT_WIDTH-1:0]  csr_write_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output lts_pkg::rsp_item_type                 rsp_item
);

   localparam int ROW_W = $clog2(NODE_LIMIT);
   localparam int CW    = lts_pkg::NODE_COUNT_WIDTH;
   localparam int IW    = lts_pkg::NODE_INDEX_WIDTH;

   logic [CW-1:0]         node_count_ff;
   logic [CW-1:0]         n_use;
   logic [NODE_LIMIT-1:0] nmask;

   logic [NODE_LIMIT-1:0] adj_ff [NODE_LIMIT];
   logic [CW-1:0]         indeg_ff [NODE_LIMIT];
   logic [NODE_LIMIT-1:0] visited_ff;
   logic [NODE_LIMIT-1:0] layer_ff;
   logic [CW-1:0]         row_ctr_ff;
   logic [CW-1:0]         emit_count_ff;
   logic                  pending_valid_ff;
   logic [IW-1:0]         pending_idx_ff;

   logic                  rsp_valid_ff;
   lts_pkg::rsp_item_type rsp_item_ff;

   logic [NODE_LIMIT-1:0] layer_w;
   logic [NODE_LIMIT-1:0] count_row_w;
   logic [NODE_LIMIT-1:0] pick_row_w;
   logic [ROW_W-1:0]      pick_idx;
   logic                  edge_ok;
   logic                  out_free;

   // nodes in use, saturated at the store size
   assign n_use = (node_count_ff > CW'(NODE_LIMIT)) ? CW'(NODE_LIMIT) : node_count_ff;

   always_comb begin
      for (int j = 0; j < NODE_LIMIT; j++) begin
         nmask[j]   = (CW'(j) < n_use);
         layer_w[j] = nmask[j] && !visited_ff[j] && (indeg_ff[j] == '0);
      end
   end

   // lowest set bit of the held layer
   always_comb begin
      pick_idx = '0;
      for (int j = NODE_LIMIT - 1; j >= 0; j--) begin
         if (layer_ff[j]) begin
            pick_idx = ROW_W'(j);
         end
      end
   end

   assign count_row_w = adj_ff[row_ctr_ff[ROW_W-1:0]] & nmask;
   assign pick_row_w  = adj_ff[pick_idx] & nmask;
   assign edge_ok     = ({1'b0, req_item.edge_source} < n_use) &&
                        ({1'b0, req_item.edge_target} < n_use);
   assign out_free    = !rsp_valid_ff || rsp_ready;

   assign status.row_done      = (row_ctr_ff >= n_use);
   assign status.layer_empty   = (layer_w == '0);
   assign status.mask_empty    = (layer_ff == '0);
   assign status.pending_valid = pending_valid_ff;
   assign status.out_free      = out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
      end else if (csr_write_enable) begin
         node_count_ff <= csr_write_data;
      end
   end

   // adjacency store: set on edge load, cleared as a whole after a run
   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         for (int i = 0; i < NODE_LIMIT; i++) begin
            adj_ff[i] <= '0;
         end
      end else if (cmd.add_edge && edge_ok) begin
         adj_ff[req_item.edge_source[ROW_W-1:0]][req_item.edge_target[ROW_W-1:0]] <= 1'b1;
      end
   end

   // in-degree lanes
   always_ff @(posedge clock) begin
      if (reset || cmd.start_run) begin
         for (int j = 0; j < NODE_LIMIT; j++) begin
            indeg_ff[j] <= '0;
         end
      end else if (cmd.count_row) begin
         for (int j = 0; j < NODE_LIMIT; j++) begin
            indeg_ff[j] <= indeg_ff[j] + CW'(count_row_w[j]);
         end
      end else if (cmd.emit_step) begin
         for (int j = 0; j < NODE_LIMIT; j++) begin
            if (pick_row_w[j] && (indeg_ff[j] != '0)) begin
               indeg_ff[j] <= indeg_ff[j] - CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff       <= '0;
         layer_ff         <= '0;
         row_ctr_ff       <= '0;
         emit_count_ff    <= '0;
         pending_valid_ff <= 1'b0;
      end else if (cmd.start_run) begin
         visited_ff       <= '0;
         layer_ff         <= '0;
         row_ctr_ff       <= '0;
         emit_count_ff    <= '0;
         pending_valid_ff <= 1'b0;
      end else begin
         if (cmd.count_row) begin
            row_ctr_ff <= row_ctr_ff + CW'(1);
         end
         if (cmd.load_layer) begin
            layer_ff <= layer_w;
         end
         if (cmd.emit_step) begin
            layer_ff[pick_idx]   <= 1'b0;
            visited_ff[pick_idx] <= 1'b1;
            emit_count_ff        <= emit_count_ff + CW'(1);
            pending_valid_ff     <= 1'b1;
         end
         if (cmd.finish) begin
            pending_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_step) begin
         pending_idx_ff <= IW'(pick_idx);
      end
   end

   // output register; the held node goes out once the next one is known or the run ends
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((cmd.emit_step && pending_valid_ff) || cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_step && pending_valid_ff) begin
         rsp_item_ff.node_index       <= pending_idx_ff;
         rsp_item_ff.node_valid       <= 1'b1;
         rsp_item_ff.last_of_order    <= 1'b0;
         rsp_item_ff.order_incomplete <= 1'b0;
      end else if (cmd.finish) begin
         rsp_item_ff.node_index       <= pending_valid_ff ? pending_idx_ff : '0;
         rsp_item_ff.node_valid       <= pending_valid_ff;
         rsp_item_ff.last_of_order    <= 1'b1;
         rsp_item_ff.order_incomplete <= (emit_count_ff < n_use);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

>>> src/layered_topological_sort.sv
// Top level of the layered topological sort block.
// Depends on lts_pkg, lts_ctrl and lts_datapath.
//
// Edge items (req_type add) load a directed graph of up to node_count nodes
// into an adjacency bit store, one item per cycle while idle; edges touching
// a node at or beyond node_count are dropped and duplicates collapse. A run
// item counts in-degrees (one adjacency row per cycle), then walks layers:
// it forms each layer from the in-degree lanes, emits the layer's nodes
// (lowest index first, each node's out-edges retired in the same cycle,
// waiting while the result side stalls) and closes the layer; once no
// further layer is found it gives the final result. The last result of a
// run has last_of_order set and order_incomplete when nodes on or behind
// a cycle were never emitted; a run that emits nothing returns a single
// result with node_valid low. The edge store clears at the end of every
// run. node_count is written through csr_; the user must write it only
// while the block is idle, and the block itself does not enforce this.
module layered_topological_sort #(
   parameter int MAX_NODES = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // item input
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  lts_pkg::req_item_type                req_item,
   // result output
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output lts_pkg::rsp_item_type                rsp_item,
   // node_count register
   input  logic                                 csr_write_enable,
   input  logic [lts_pkg::NODE_COUNT_WIDTH-1:0] csr_write_data
);

   // node indices are five bits, so the store never exceeds 32 nodes
   localparam int NODE_LIMIT = (MAX_NODES < 32) ? MAX_NODES : 32;

   lts_pkg::cmd_type    cmd;
   lts_pkg::status_type status;

   // sequencer: takes items only while idle
   lts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_item.req_type),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // graph store, in-degree lanes and output register
   lts_datapath #(
      .NODE_LIMIT (NODE_LIMIT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_item         (req_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item         (rsp_item)
   );

endmodule

>>> tb/sv/tb_layered_topological_sort.sv
// Self-checking testbench for the layered topological sort block.
// Depends on lts_pkg and layered_topological_sort; holds its own model of the
// edge store and of the layer-by-layer sort, and checks every result item.
module tb_layered_topological_sort;

   localparam int NODE_SLOTS   = 32;    // nodes the block can hold
   localparam int ITEM_TARGET  = 225;   // items before random graphs stop; the last graph still finishes
   localparam int SETTLE       = 16;    // quiet cycles before a node_count write
   localparam int WATCHDOG_MAX = 1000;  // cycles without any handshake or node_count write

   // ---------------------------------------------------------------------
   // Clock, reset and block ports. Every input has a known value at time 0.
   // ---------------------------------------------------------------------
   logic                           clock            = 1'b0;
   logic                           reset            = 1'b1;
   logic                           req_valid        = 1'b0;
   logic                           req_ready;
   lts_pkg::req_item_type          req_item         = '0;
   logic                           rsp_valid;
   logic                           rsp_ready        = 1'b0;
   lts_pkg::rsp_item_type          rsp_item;
   logic                           csr_write_enable = 1'b0;
   logic [lts_pkg::NODE_COUNT_WIDTH-1:0] csr_write_data = '0;

   always #6 clock = ~clock;

   layered_topological_sort #(
      .MAX_NODES(NODE_SLOTS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_item        (req_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_item        (rsp_item),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   // ---------------------------------------------------------------------
   // Mirror of the block: edge rows (bit t of row s = edge s->t), the
   // node_count register, and the queue of node results still to come.
   // ---------------------------------------------------------------------
   logic [NODE_SLOTS-1:0]                edge_rows [NODE_SLOTS];
   logic [lts_pkg::NODE_COUNT_WIDTH-1:0] node_count_reg = '0;
   lts_pkg::rsp_item_type                order_queue [$];

   int items_sent      = 0;
   int runs_sent       = 0;
   int count_writes    = 0;
   int results_checked = 0;
   int mismatches      = 0;
   int quiet_cycles    = 0;

   bit gaps_on   = 1'b1;   // sender inserts idle cycles
   bit stalls_on = 1'b1;   // receiver drops rsp_ready now and then
   int stall_left = 0;

   lts_pkg::rsp_item_type want;

   // node_count saturates at the store size
   function automatic int active_nodes();
      return (node_count_reg > NODE_SLOTS) ? NODE_SLOTS : int'(node_count_reg);
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap(int long_max);
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, long_max);
   endfunction

   // Applies one accepted item to the mirror. An edge item only touches the
   // store; a run item works out the whole emitted order and clears the store.
   task automatic sort_layers(input lts_pkg::req_item_type item);
      int n;
      int i;
      int j;
      logic [5:0]            degree [NODE_SLOTS];
      logic [NODE_SLOTS-1:0] emitted;
      logic [NODE_SLOTS-1:0] layer;
      lts_pkg::rsp_item_type run_out [$];
      lts_pkg::rsp_item_type r;
      n = active_nodes();
      if (item.req_type == lts_pkg::REQ_ADD_EDGE) begin
         // edges touching a node outside the count in use are dropped
         if (item.edge_source < n && item.edge_target < n)
            edge_rows[item.edge_source][item.edge_target] = 1'b1;
         return;
      end
      for (i = 0; i < NODE_SLOTS; i++)
         degree[i] = '0;
      emitted = '0;
      // in-degrees only count edges between nodes in use right now
      for (i = 0; i < n; i++)
         for (j = 0; j < n; j++)
            if (edge_rows[i][j])
               degree[j] = degree[j] + 6'd1;
      while (1) begin
         layer = '0;
         for (i = 0; i < n; i++)
            if (degree[i] == 0 && !emitted[i])
               layer[i] = 1'b1;
         if (layer == '0)
            break;
         for (i = 0; i < n; i++) begin
            if (layer[i]) begin
               r.node_index       = 5'(i);
               r.node_valid       = 1'b1;
               r.last_of_order    = 1'b0;
               r.order_incomplete = 1'b0;
               run_out = {run_out, r};
               emitted[i] = 1'b1;
            end
         end
         // retire the out-edges of the whole layer before the next one
         for (i = 0; i < n; i++)
            if (layer[i])
               for (j = 0; j < n; j++)
                  if (edge_rows[i][j] && degree[j] != 0)
                     degree[j] = degree[j] - 6'd1;
      end
      if (run_out.size() == 0) begin
         // nothing emitted: one marker result, incomplete only if nodes exist
         r.node_index       = '0;
         r.node_valid       = 1'b0;
         r.last_of_order    = 1'b1;
         r.order_incomplete = (n > 0);
         run_out = {run_out, r};
      end else begin
         r = run_out.pop_back();
         r.last_of_order    = 1'b1;
         r.order_incomplete = (run_out.size() + 1 < n);
         run_out = {run_out, r};
      end
      order_queue = {order_queue, run_out};
      for (i = 0; i < NODE_SLOTS; i++)
         edge_rows[i] = '0;
   endtask

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------
   // Sender. Called at a rising edge; valid stays high across back-to-back
   // items and is lowered only for a gap or a drain, so it never drops and
   // rises in the same step.
   // ---------------------------------------------------------------------
   task automatic send_item(input lts_pkg::req_item_type item);
      int gap;
      gap = gaps_on ? pick_gap(30) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_item  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sort_layers(item);
      items_sent++;
   endtask

   task automatic add_edge(input int unsigned source, input int unsigned target);
      lts_pkg::req_item_type item;
      item.req_type    = lts_pkg::REQ_ADD_EDGE;
      item.edge_source = 5'(source);
      item.edge_target = 5'(target);
      send_item(item);
   endtask

   task automatic run_sort();
      lts_pkg::req_item_type item;
      // edge fields are don't-care on a run; randomize them anyway
      item.req_type    = lts_pkg::REQ_RUN;
      item.edge_source = 5'($urandom);
      item.edge_target = 5'($urandom);
      send_item(item);
      runs_sent++;
   endtask

   // Stop sending until every expected node result is back, then let the
   // block settle (edge writes and the end-of-run clear leave no result).
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (order_queue.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // node_count is only written while the block is idle
   task automatic set_node_count(input logic [lts_pkg::NODE_COUNT_WIDTH-1:0] value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      node_count_reg = value;
      count_writes++;
   endtask

   // mostly small graphs, sometimes the full store or saturating counts
   function automatic logic [lts_pkg::NODE_COUNT_WIDTH-1:0] pick_node_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 6'($urandom_range(2, 10));
      if (r < 80) return 6'($urandom_range(11, 31));
      if (r < 88) return 6'(NODE_SLOTS);
      if (r < 94) return 6'($urandom_range(33, 63));
      return 6'($urandom_range(0, 1));
   endfunction

   // ---------------------------------------------------------------------
   // Directed tests
   // ---------------------------------------------------------------------

   // Reset count is zero: the edge is dropped and the run gives one
   // not-valid result with no incomplete flag.
   task automatic test_empty_graph();
      add_edge(0, 0);
      run_sort();
   endtask

   // One node emits itself; a self loop then keeps it from ever emitting.
   task automatic test_single_node_and_self_loop();
      set_node_count(6'd1);
      run_sort();
      add_edge(0, 0);
      run_sort();
   endtask

   // Three layers: {3,4}, {1,2}, {0}. A duplicate edge collapses and edges
   // with an end at or beyond the count are dropped.
   task automatic test_layers_and_duplicates();
      set_node_count(6'd5);
      add_edge(3, 1);
      add_edge(3, 1);
      add_edge(1, 0);
      add_edge(4, 2);
      add_edge(5, 0);
      add_edge(0, 7);
      run_sort();
   endtask

   // 1 and 2 form a cycle and 3 hangs behind it: only 0 comes out and the
   // last result carries the incomplete flag.
   task automatic test_cycle();
      set_node_count(6'd4);
      add_edge(0, 1);
      add_edge(1, 2);
      add_edge(2, 1);
      add_edge(2, 3);
      run_sort();
   endtask

   // Edges loaded with all 32 nodes, count then lowered to 3: only 2->1
   // is still in play at run time.
   task automatic test_count_lowered();
      set_node_count(6'd32);
      add_edge(31, 0);
      add_edge(0, 31);
      add_edge(2, 1);
      set_node_count(6'd3);
      run_sort();
   endtask

   // Count of 63 saturates to the store size: 32 results, all one layer.
   task automatic test_full_width();
      set_node_count(6'd63);
      run_sort();
   endtask

   // ---------------------------------------------------------------------
   // Random graphs: mostly acyclic graphs drawn over a shuffled node order,
   // with some back edges (cycles), noise edges between any of nodes 0..31, and the odd
   // count change between loading and the run.
   // ---------------------------------------------------------------------
   task automatic test_random_graphs();
      int n;
      int edges;
      int a;
      int b;
      int j;
      int r;
      int tmp;
      int graphs;
      int order [NODE_SLOTS];
      bit paused;
      paused = 1'b0;
      while (items_sent < ITEM_TARGET) begin
         // some phases run with no idling on one side or both
         gaps_on   = ($urandom_range(0, 9) < 7);
         stalls_on = ($urandom_range(0, 9) < 7);
         set_node_count(pick_node_count());
         graphs = $urandom_range(1, 4);
         while (graphs > 0 && items_sent < ITEM_TARGET) begin
            graphs--;
            n = active_nodes();
            if (!paused || $urandom_range(0, 19) == 0) begin
               drain_results();
               paused = 1'b1;
            end
            for (j = 0; j < NODE_SLOTS; j++)
               order[j] = j;
            for (j = n - 1; j > 0; j--) begin
               a        = $urandom_range(0, j);
               tmp      = order[j];
               order[j] = order[a];
               order[a] = tmp;
            end
            edges = (n < 2) ? $urandom_range(0, 3)
                            : $urandom_range(0, (2 * n > 40) ? 40 : 2 * n);
            repeat (edges) begin
               r = $urandom_range(0, 99);
               if (n < 2 || r < 12) begin
                  add_edge($urandom_range(0, 31), $urandom_range(0, 31));
               end else begin
                  a = $urandom_range(0, n - 2);
                  b = $urandom_range(a + 1, n - 1);
                  if (r < 18)
                     add_edge(order[b], order[a]);   // may close a cycle
                  else
                     add_edge(order[a], order[b]);
               end
            end
            if ($urandom_range(0, 9) == 0)
               set_node_count(pick_node_count());
            run_sort();
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Receiver: rsp_ready stalls in random bursts, mostly short.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (stalls_on)
            stall_left = pick_gap(40);
      end
   end

   // Result checker: each accepted result against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (order_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected result node %0d valid %0b",
                                      rsp_item.node_index, rsp_item.node_valid));
         end else begin
            want = order_queue.pop_front();
            results_checked++;
            if (rsp_item.node_index !== want.node_index)
               report_mismatch($sformatf("node_index got %0d expected %0d",
                                         rsp_item.node_index, want.node_index));
            if (rsp_item.node_valid !== want.node_valid)
               report_mismatch($sformatf("node_valid got %0b expected %0b",
                                         rsp_item.node_valid, want.node_valid));
            if (rsp_item.last_of_order !== want.last_of_order)
               report_mismatch($sformatf("last_of_order got %0b expected %0b",
                                         rsp_item.last_of_order, want.last_of_order));
            if (rsp_item.order_incomplete !== want.order_incomplete)
               report_mismatch($sformatf("order_incomplete got %0b expected %0b",
                                         rsp_item.order_incomplete,
                                         want.order_incomplete));
         end
      end
   end

   // Watchdog: any handshake or register write counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_MAX) begin
         $display("[%0t] watchdog: no progress for %0d cycles", $realtime,
                  WATCHDOG_MAX);
         $display("tb_layered_topological_sort: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      for (int i = 0; i < NODE_SLOTS; i++)
         edge_rows[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_graph();
      test_single_node_and_self_loop();
      test_layers_and_duplicates();
      test_cycle();
      test_count_lowered();
      test_full_width();
      test_random_graphs();

      // wait out the last results, then watch for strays
      drain_results();
      repeat (2 * NODE_SLOTS) @(posedge clock);

      $display("covered %0d items in %0d runs over %0d node_count settings",
               items_sent, runs_sent, count_writes);
      $display("%0d node results checked, %0d mismatches",
               results_checked, mismatches);
      if (mismatches == 0 && order_queue.size() == 0)
         $display("tb_layered_topological_sort: PASS");
      else
         $display("tb_layered_topological_sort: FAIL");
      $finish;
   end

endmodule
